### rtl/core/vtxce_pkg.sv
// Types, codes and frame helpers of the video transmitter command exchanger.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package vtxce_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int REPLY_BYTES = 15;
    localparam int SUM_SPAN    = 13;

    localparam logic [7:0]  MAGIC_BYTE   = 8'h0F;
    localparam logic [7:0]  CMD_LIMITS   = 8'h72;  // 'r'
    localparam logic [7:0]  CMD_SETTINGS = 8'h76;  // 'v'
    localparam logic [7:0]  CMD_TEMP     = 8'h73;  // 's'
    localparam logic [15:0] GUARD_RESET   = 16'd500;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Configuration register indexes.
    localparam logic CFG_GUARD   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_WAITING = 2'd1;
    localparam logic [1:0] ST_SUCCESS = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    // Reply kinds.
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_LIMITS   = 2'd1;
    localparam logic [1:0] KIND_SETTINGS = 2'd2;
    localparam logic [1:0] KIND_TEMP     = 2'd3;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RX_BYTE = 2'd1,
        OP_TICK    = 2'd2
    } t_opcode;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_ERROR = 6'b000010,
        PH_INIT  = 6'b000100,
        PH_ECHO  = 6'b001000,
        PH_MAGIC = 6'b010000,
        PH_REPLY = 6'b100000
    } t_phase;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  status;
        logic [1:0]  report_kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
    } t_result;

    function automatic logic [7:0] frame_byte(input logic [3:0] idx,
                                              input logic [7:0] cmd,
                                              input logic [15:0] value);
        logic [7:0] sum;
        sum = cmd + value[7:0] + value[15:8];
        case (idx)
            4'd0:    frame_byte = MAGIC_BYTE;
            4'd1:    frame_byte = cmd;
            4'd2:    frame_byte = value[7:0];
            4'd3:    frame_byte = value[15:8];
            4'd14:   frame_byte = sum;
            default: frame_byte = 8'h00;
        endcase
    endfunction

    function automatic logic is_query(input logic [7:0] cmd);
        is_query = (cmd == CMD_LIMITS) || (cmd == CMD_SETTINGS) || (cmd == CMD_TEMP);
    endfunction

endpackage

### rtl/core/video_tx_command_exchanger.sv
// Top level of the video transmitter command exchanger: frame builder, echo and
// reply checker, millisecond counters and result register. Uses vtxce_pkg.
//
// Usage: the slave stream carries requests, received line bytes and 1 ms ticks,
// selected by s_axis_tuser. Each request's state update is done between the
// input handshake and the result register, so its result is registered and
// shows on the master stream in the cycle after the request is accepted.
// A request that leaves one result (status only, tlast high) lets the next
// request follow in the next cycle: one request per cycle while the receiver
// takes the results. A request that lets the frame go out leaves 16 results
// (tuser high, the frame bytes in order, tlast on the last); they leave the
// result register one per cycle unless the receiver stalls, and the slave side
// stays not ready until the last frame byte sits in the result register.
// The single result register parts the two sides: a new request is taken while
// the current result is being taken in the same cycle. When the receiver stalls
// the result holds and the slave side stalls with it.
// A synchronous active-low reset returns to idle with both counters at zero and
// both timing registers at 500 ms; the reply bytes hold no reset value.
// Configuration writes take effect at the clock edge of the write.
module video_tx_command_exchanger (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] request_cmd, [23:8] request_value, [31:24] rx_byte
    input  logic [31:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte, [9:8] status, [11:10] report_kind, [27:12] word_a,
    // [43:28] word_b, [59:44] word_c, [67:60] byte_a, [75:68] byte_b, zero pad
    output logic [79:0] m_axis_tdata,
    // [0] tx_valid
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import vtxce_pkg::*;

    logic [15:0] r_guard_ms;
    logic [15:0] r_timeout_ms;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held_cmd, n_held_cmd;
    logic [15:0] r_held_value, n_held_value;
    logic [3:0]  r_echo_idx, n_echo_idx;
    logic [3:0]  r_reply_idx, n_reply_idx;
    logic [7:0]  r_reply_sum, n_reply_sum;
    logic [15:0] r_since_read, n_since_read;
    logic [15:0] r_since_send, n_since_send;
    logic [7:0]  r_store [0:REPLY_BYTES-1];

    logic        r_burst;
    logic [3:0]  r_tx_idx;
    logic        r_out_valid;
    t_result     r_out;

    logic        in_accept;
    logic        out_free;
    logic        burst_load;
    logic        store_we;
    logic        send;
    logic        done;
    logic        in_flight;
    t_opcode     op;
    logic [7:0]  rx_d;
    logic [15:0] read_inc, send_inc;
    t_result     single_res;
    t_result     burst_res;
    t_result     first_res;

    assign op       = t_opcode'(s_axis_tuser);
    assign rx_d     = s_axis_tdata[31:24];
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = !r_burst && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign burst_load    = r_burst && out_free;

    assign in_flight = (r_phase == PH_ECHO) || (r_phase == PH_MAGIC) || (r_phase == PH_REPLY);
    assign read_inc  = (r_since_read == COUNT_MAX) ? r_since_read : r_since_read + 16'd1;
    assign send_inc  = (r_since_send == COUNT_MAX) ? r_since_send : r_since_send + 16'd1;
    assign store_we  = in_accept && (op == OP_RX_BYTE) && (r_phase == PH_REPLY);

    always_comb begin
        n_phase      = r_phase;
        n_held_cmd   = r_held_cmd;
        n_held_value = r_held_value;
        n_echo_idx   = r_echo_idx;
        n_reply_idx  = r_reply_idx;
        n_reply_sum  = r_reply_sum;
        n_since_read = r_since_read;
        n_since_send = r_since_send;
        done         = 1'b0;
        send         = 1'b0;
        single_res   = '0;

        case (op)
            OP_REQUEST: begin
                n_held_cmd   = s_axis_tdata[7:0];
                n_held_value = s_axis_tdata[23:8];
                n_phase      = PH_INIT;
                n_since_read = '0;
            end
            OP_TICK: begin
                n_since_send = send_inc;
                n_since_read = read_inc;
                if (in_flight && (read_inc > r_timeout_ms)) begin
                    n_phase = PH_ERROR;
                end
            end
            OP_RX_BYTE: begin
                if (in_flight) begin
                    n_since_read = '0;
                    unique case (r_phase)
                        PH_ECHO: begin
                            if (frame_byte(r_echo_idx, r_held_cmd, r_held_value) != rx_d) begin
                                n_phase = PH_ERROR;
                            end else begin
                                n_echo_idx = r_echo_idx + 4'd1;
                                if (r_echo_idx == 4'(FRAME_BYTES - 1)) begin
                                    if (is_query(r_held_cmd)) begin
                                        n_phase = PH_MAGIC;
                                    end else begin
                                        n_phase = PH_IDLE;
                                        done    = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_MAGIC: begin
                            if (rx_d != MAGIC_BYTE) begin
                                n_phase = PH_ERROR;
                            end else begin
                                n_phase     = PH_REPLY;
                                n_reply_idx = '0;
                                n_reply_sum = '0;
                            end
                        end
                        PH_REPLY: begin
                            if (r_reply_idx < 4'(SUM_SPAN)) begin
                                n_reply_sum = r_reply_sum + rx_d;
                            end
                            n_reply_idx = r_reply_idx + 4'd1;
                            // The byte taken now is the trailing zero of the reply.
                            if (r_reply_idx == 4'(REPLY_BYTES - 1)) begin
                                if ((r_store[13] != r_reply_sum) || (rx_d != 8'h00)) begin
                                    n_phase = PH_ERROR;
                                end else begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                    case (r_store[0])
                                        CMD_LIMITS: begin
                                            single_res.report_kind = KIND_LIMITS;
                                            single_res.word_a = {r_store[2], r_store[1]};
                                            single_res.word_b = {r_store[4], r_store[3]};
                                            single_res.word_c = {r_store[6], r_store[5]};
                                        end
                                        CMD_SETTINGS: begin
                                            single_res.report_kind = KIND_SETTINGS;
                                            single_res.word_a = {r_store[2], r_store[1]};
                                            single_res.word_b = {r_store[4], r_store[3]};
                                            single_res.byte_a = r_store[5];
                                            single_res.byte_b = r_store[6];
                                            single_res.word_c = {r_store[8], r_store[7]};
                                        end
                                        CMD_TEMP: begin
                                            single_res.report_kind = KIND_TEMP;
                                            single_res.word_a = {r_store[2], r_store[1]};
                                        end
                                        default: begin
                                            single_res.report_kind = KIND_NONE;
                                        end
                                    endcase
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // The send check runs at the end of every request.
        if ((n_phase == PH_INIT) && (n_since_send > r_guard_ms)) begin
            send         = 1'b1;
            n_since_send = '0;
            n_echo_idx   = '0;
            n_reply_idx  = '0;
            n_reply_sum  = '0;
            n_phase      = PH_ECHO;
        end

        single_res.tx_valid = 1'b0;
        single_res.tx_byte  = '0;
        single_res.last     = 1'b1;
        if (done) begin
            single_res.status = ST_SUCCESS;
        end else if (n_phase == PH_IDLE) begin
            single_res.status = ST_IDLE;
        end else if (n_phase == PH_ERROR) begin
            single_res.status = ST_ERROR;
        end else begin
            single_res.status = ST_WAITING;
        end
    end

    always_comb begin
        first_res          = '0;
        first_res.tx_valid = 1'b1;
        first_res.tx_byte  = MAGIC_BYTE;
        first_res.status   = ST_WAITING;

        burst_res          = '0;
        burst_res.tx_valid = 1'b1;
        burst_res.tx_byte  = frame_byte(r_tx_idx, r_held_cmd, r_held_value);
        burst_res.last     = (r_tx_idx == 4'(FRAME_BYTES - 1));
        burst_res.status   = ST_WAITING;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_ms   <= GUARD_RESET;
            r_timeout_ms <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_GUARD) begin
                r_guard_ms <= i_cfg_wdata;
            end else begin
                r_timeout_ms <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_held_cmd   <= '0;
            r_held_value <= '0;
            r_echo_idx   <= '0;
            r_reply_idx  <= '0;
            r_reply_sum  <= '0;
            r_since_read <= '0;
            r_since_send <= '0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_held_cmd   <= n_held_cmd;
            r_held_value <= n_held_value;
            r_echo_idx   <= n_echo_idx;
            r_reply_idx  <= n_reply_idx;
            r_reply_sum  <= n_reply_sum;
            r_since_read <= n_since_read;
            r_since_send <= n_since_send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_reply_idx] <= rx_d;
        end
    end

    // Result register and frame byte sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_burst     <= 1'b0;
            r_tx_idx    <= '0;
        end else begin
            if (in_accept) begin
                r_out_valid <= 1'b1;
                if (send) begin
                    r_burst  <= 1'b1;
                    r_tx_idx <= 4'd1;
                end
            end else if (burst_load) begin
                r_out_valid <= 1'b1;
                r_tx_idx    <= r_tx_idx + 4'd1;
                if (r_tx_idx == 4'(FRAME_BYTES - 1)) begin
                    r_burst <= 1'b0;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (send) begin
                r_out <= first_res;
            end else begin
                r_out <= single_res;
            end
        end else if (burst_load) begin
            r_out <= burst_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.tx_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {4'b0000, r_out.byte_b, r_out.byte_a, r_out.word_c,
                            r_out.word_b, r_out.word_a, r_out.report_kind,
                            r_out.status, r_out.tx_byte};

endmodule

### rtl/core/vtxce_chk.sv
// Port checker for video_tx_command_exchanger and the bind that attaches it.
// Uses vtxce_pkg for the status codes; sees the top level's ports only.
module vtxce_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import vtxce_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // A status result is always the last result of its request.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("status result without tlast");

    // While frame bytes remain, no new request is taken.
    a_frame_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast |-> !s_axis_tready)
        else $error("request taken in the middle of a frame");

    // Frame bytes report the waiting status.
    a_frame_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[9:8] == ST_WAITING)
        else $error("frame byte with wrong status");

endmodule

bind video_tx_command_exchanger vtxce_chk u_vtxce_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### dv/testbench.sv
// Self-checking testbench for video_tx_command_exchanger: walks a directed table, then
// random request, echo and reply sequences under several guard and timeout settings.
// Depends only on vtxce_pkg and the block itself.
module testbench;
    import vtxce_pkg::*;

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         LONG_HOLD     = 400;
    localparam int         DIRECTED_ROWS = 19;
    localparam int         CONFIG_ROW    = 6;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cmd;
        logic [15:0] value;
        logic [7:0]  rx;
    } t_line_item;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cmd;
        logic [15:0] value;
        logic [7:0]  rx;
        logic        typed;
        logic [1:0]  status;
    } t_directed_row;

    // Rows before CONFIG_ROW run with the reset timing; the rest with guard 0 and timeout 0.
    // Where typed is set the row leaves one status result with the given status.
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{OP_TICK,    8'h00,        16'h0000, 8'h00,      1'b1, ST_IDLE},
        '{OP_RX_BYTE, 8'h00,        16'h0000, 8'hFF,      1'b1, ST_IDLE},
        '{OP_UNUSED,  8'hFF,        16'hFFFF, 8'hFF,      1'b1, ST_IDLE},
        '{OP_REQUEST, 8'hFF,        16'hFFFF, 8'h00,      1'b1, ST_WAITING},
        '{OP_RX_BYTE, 8'h00,        16'h0000, MAGIC_BYTE, 1'b1, ST_WAITING},
        '{OP_TICK,    8'h00,        16'h0000, 8'h00,      1'b1, ST_WAITING},
        '{OP_REQUEST, 8'h00,        16'h0000, 8'h00,      1'b0, ST_IDLE},
        '{OP_RX_BYTE, 8'h00,        16'h0000, MAGIC_BYTE, 1'b1, ST_WAITING},
        '{OP_TICK,    8'h00,        16'h0000, 8'h00,      1'b1, ST_ERROR},
        '{OP_RX_BYTE, 8'h00,        16'h0000, 8'h00,      1'b1, ST_ERROR},
        '{OP_TICK,    8'h00,        16'h0000, 8'h00,      1'b1, ST_ERROR},
        '{OP_REQUEST, CMD_SETTINGS, 16'h1234, 8'h00,      1'b0, ST_IDLE},
        '{OP_RX_BYTE, 8'h00,        16'h0000, 8'h0E,      1'b1, ST_ERROR},
        '{OP_REQUEST, CMD_TEMP,     16'h8000, 8'h00,      1'b1, ST_WAITING},
        '{OP_TICK,    8'h00,        16'h0000, 8'h00,      1'b0, ST_IDLE},
        '{OP_RX_BYTE, 8'h00,        16'h0000, MAGIC_BYTE, 1'b1, ST_WAITING},
        '{OP_RX_BYTE, 8'h00,        16'h0000, CMD_TEMP,   1'b1, ST_WAITING},
        '{OP_REQUEST, CMD_LIMITS,   16'h00FF, 8'h00,      1'b1, ST_WAITING},
        '{OP_TICK,    8'h00,        16'h0000, 8'h00,      1'b0, ST_IDLE}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [7:0] request_cmd, [23:8] request_value, [31:24] rx_byte
    logic [1:0]  s_axis_tuser;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // [7:0] tx_byte, [9:8] status, [11:10] report_kind,
                                 // [27:12] word_a, [43:28] word_b, [59:44] word_c,
                                 // [67:60] byte_a, [75:68] byte_b
    logic [0:0]  m_axis_tuser;   // [0] tx_valid
    logic        m_axis_tlast;

    video_tx_command_exchanger i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow of the exchanger state and its timing registers.
    t_phase      link_phase;
    logic [7:0]  req_cmd;
    logic [15:0] req_value;
    logic [4:0]  echo_pos;
    logic [4:0]  reply_pos;
    logic [7:0]  reply_bytes [REPLY_BYTES];
    logic [7:0]  reply_acc;
    logic [15:0] quiet_ms;
    logic [15:0] send_gap_ms;
    logic [15:0] guard_setting;
    logic [15:0] timeout_setting;

    t_result     expected_results [$];
    t_line_item  stim_q [$];

    int   fail_count;
    int   items_sent;
    int   settings_count;
    int   results_checked;
    int   exchanges_ok;
    int   error_reports;
    int   cycle_count;
    logic sender_burst;
    logic long_hold_armed;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] line_byte(input int idx, input logic [7:0] cmd,
                                             input logic [15:0] value);
        logic [7:0] chk;
        chk = cmd + value[7:0] + value[15:8];
        if (idx == 0) return MAGIC_BYTE;
        if (idx == 1) return cmd;
        if (idx == 2) return value[7:0];
        if (idx == 3) return value[15:8];
        if (idx == FRAME_BYTES - 2) return chk;
        return 8'h00;
    endfunction

    function automatic logic expects_reply(input logic [7:0] cmd);
        return cmd == CMD_LIMITS || cmd == CMD_SETTINGS || cmd == CMD_TEMP;
    endfunction

    function automatic logic exchange_live();
        return link_phase == PH_ECHO || link_phase == PH_MAGIC || link_phase == PH_REPLY;
    endfunction

    // Advances the shadow state by one accepted request and queues the results it leaves.
    task automatic predict_step(input t_line_item it, input logic use_typed,
                                input logic [1:0] typed_status);
        t_result r;
        logic    finished;
        int      k;
        r = '0;
        finished = 1'b0;
        case (it.op)
            OP_REQUEST: begin
                req_cmd = it.cmd;
                req_value = it.value;
                link_phase = PH_INIT;
                quiet_ms = '0;
            end
            OP_TICK: begin
                if (send_gap_ms != COUNT_MAX) send_gap_ms = send_gap_ms + 1'b1;
                if (quiet_ms != COUNT_MAX) quiet_ms = quiet_ms + 1'b1;
                if (exchange_live() && quiet_ms > timeout_setting) link_phase = PH_ERROR;
            end
            OP_RX_BYTE: begin
                if (exchange_live()) begin
                    quiet_ms = '0;
                    if (link_phase == PH_ECHO) begin
                        if (line_byte(echo_pos, req_cmd, req_value) != it.rx) begin
                            link_phase = PH_ERROR;
                        end else begin
                            echo_pos = echo_pos + 1'b1;
                            if (echo_pos == FRAME_BYTES) begin
                                if (expects_reply(req_cmd)) begin
                                    link_phase = PH_MAGIC;
                                end else begin
                                    link_phase = PH_IDLE;
                                    finished = 1'b1;
                                end
                            end
                        end
                    end else if (link_phase == PH_MAGIC) begin
                        if (it.rx != MAGIC_BYTE) begin
                            link_phase = PH_ERROR;
                        end else begin
                            link_phase = PH_REPLY;
                            reply_pos = '0;
                            reply_acc = '0;
                        end
                    end else begin
                        reply_bytes[reply_pos] = it.rx;
                        if (reply_pos < SUM_SPAN) reply_acc = reply_acc + it.rx;
                        reply_pos = reply_pos + 1'b1;
                        if (reply_pos == REPLY_BYTES) begin
                            if (reply_bytes[SUM_SPAN] != reply_acc ||
                                reply_bytes[REPLY_BYTES - 1] != 8'h00) begin
                                link_phase = PH_ERROR;
                            end else begin
                                link_phase = PH_IDLE;
                                finished = 1'b1;
                                case (reply_bytes[0])
                                    CMD_LIMITS: begin
                                        r.report_kind = KIND_LIMITS;
                                        r.word_a = {reply_bytes[2], reply_bytes[1]};
                                        r.word_b = {reply_bytes[4], reply_bytes[3]};
                                        r.word_c = {reply_bytes[6], reply_bytes[5]};
                                    end
                                    CMD_SETTINGS: begin
                                        r.report_kind = KIND_SETTINGS;
                                        r.word_a = {reply_bytes[2], reply_bytes[1]};
                                        r.word_b = {reply_bytes[4], reply_bytes[3]};
                                        r.byte_a = reply_bytes[5];
                                        r.byte_b = reply_bytes[6];
                                        r.word_c = {reply_bytes[8], reply_bytes[7]};
                                    end
                                    CMD_TEMP: begin
                                        r.report_kind = KIND_TEMP;
                                        r.word_a = {reply_bytes[2], reply_bytes[1]};
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // The guard is checked after every request, so a frame can leave on any of them.
        if (link_phase == PH_INIT && send_gap_ms > guard_setting) begin
            send_gap_ms = '0;
            echo_pos = '0;
            reply_pos = '0;
            reply_acc = '0;
            link_phase = PH_ECHO;
            for (k = 0; k < FRAME_BYTES; k++) begin
                r = '0;
                r.tx_valid = 1'b1;
                r.tx_byte = line_byte(k, req_cmd, req_value);
                r.last = (k == FRAME_BYTES - 1);
                r.status = ST_WAITING;
                expected_results.push_back(r);
            end
        end else begin
            r.last = 1'b1;
            if (use_typed) r.status = typed_status;
            else if (finished) r.status = ST_SUCCESS;
            else if (link_phase == PH_IDLE) r.status = ST_IDLE;
            else if (link_phase == PH_ERROR) r.status = ST_ERROR;
            else r.status = ST_WAITING;
            expected_results.push_back(r);
        end
    endtask

    task automatic present_item(input t_line_item it, input int gap, input logic use_typed,
                                input logic [1:0] typed_status);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= {it.rx, it.value, it.cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_step(it, use_typed, typed_status);
        items_sent++;
    endtask

    // Lets every outstanding result drain, then writes both timing registers.
    task automatic settle_and_write(input logic [15:0] guard_val, input logic [15:0] timeout_val);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_GUARD;
        i_cfg_wdata <= guard_val;
        @(posedge i_clk);
        i_cfg_addr <= CFG_TIMEOUT;
        i_cfg_wdata <= timeout_val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        guard_setting = guard_val;
        timeout_setting = timeout_val;
        settings_count++;
    endtask

    function automatic t_line_item random_item(input logic [1:0] op);
        t_line_item it;
        it.op = op;
        it.cmd = 8'($urandom_range(0, 255));
        it.value = 16'($urandom_range(0, 65535));
        it.rx = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic push_rx(input logic [7:0] b);
        t_line_item it;
        it = random_item(OP_RX_BYTE);
        it.rx = b;
        stim_q.push_back(it);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) stim_q.push_back(random_item(OP_TICK));
    endtask

    task automatic queue_noise(input int n);
        repeat (n) stim_q.push_back(random_item(2'($urandom_range(0, 3))));
    endtask

    // One request with its echo and, for queries, a reply; about three in ten carry a fault.
    task automatic queue_exchange();
        t_line_item  it;
        logic [7:0]  cmd;
        logic [7:0]  chk;
        logic [15:0] value;
        logic [7:0]  reply [REPLY_BYTES];
        int          fault;
        int          spot;
        int          k;
        fault = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 7) : 0;
        case ($urandom_range(0, 3))
            0: cmd = CMD_LIMITS;
            1: cmd = CMD_SETTINGS;
            2: cmd = CMD_TEMP;
            default: cmd = 8'($urandom_range(0, 255));
        endcase
        value = 16'($urandom_range(0, 65535));
        // With a guard below 8 these ticks open the guard window so the frame leaves at once.
        push_ticks((guard_setting < 8) ? int'(guard_setting) + 1 : 3);
        it = random_item(OP_REQUEST);
        it.cmd = cmd;
        it.value = value;
        stim_q.push_back(it);

        spot = $urandom_range(0, FRAME_BYTES - 1);
        for (k = 0; k < FRAME_BYTES; k++) begin
            if (fault == 5 && k == spot) return;
            if (fault == 6 && k == spot && timeout_setting <= 40) begin
                push_ticks(int'(timeout_setting) + 1);
            end else if (timeout_setting != 0 && $urandom_range(0, 9) == 0) begin
                push_ticks(1);
            end
            if (fault == 1 && k == spot) begin
                push_rx(line_byte(k, cmd, value) ^ 8'($urandom_range(1, 255)));
                repeat ($urandom_range(0, 2)) push_rx(8'($urandom_range(0, 255)));
                return;
            end
            push_rx(line_byte(k, cmd, value));
        end
        if (!expects_reply(cmd)) return;

        if (fault == 2) begin
            push_rx(MAGIC_BYTE ^ 8'($urandom_range(1, 255)));
            return;
        end
        push_rx(MAGIC_BYTE);
        reply[0] = (fault == 7) ? 8'($urandom_range(0, 255)) : cmd;
        for (k = 1; k < SUM_SPAN; k++) reply[k] = 8'($urandom_range(0, 255));
        chk = '0;
        for (k = 0; k < SUM_SPAN; k++) chk = chk + reply[k];
        reply[SUM_SPAN] = (fault == 3) ? chk ^ 8'($urandom_range(1, 255)) : chk;
        reply[REPLY_BYTES - 1] = (fault == 4) ? 8'($urandom_range(1, 255)) : 8'h00;
        for (k = 0; k < REPLY_BYTES; k++) begin
            if (timeout_setting != 0 && $urandom_range(0, 9) == 0) push_ticks(1);
            push_rx(reply[k]);
        end
    endtask

    task automatic drive_queued();
        t_line_item it;
        while (stim_q.size() != 0) begin
            it = stim_q.pop_front();
            present_item(it, sender_burst ? 0 : $urandom_range(0, 5), 1'b0, ST_IDLE);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        results_checked++;
        if (m_axis_tdata[9:8] == ST_SUCCESS) exchanges_ok++;
        if (m_axis_tdata[9:8] == ST_ERROR) error_reports++;
        if (expected_results.size() == 0) begin
            $error("result with no pending expectation: tdata %0h", m_axis_tdata);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("tx_valid", 16'(want.tx_valid), 16'(m_axis_tuser[0]));
            compare_field("tx_byte", 16'(want.tx_byte), 16'(m_axis_tdata[7:0]));
            compare_field("last", 16'(want.last), 16'(m_axis_tlast));
            compare_field("status", 16'(want.status), 16'(m_axis_tdata[9:8]));
            compare_field("report_kind", 16'(want.report_kind), 16'(m_axis_tdata[11:10]));
            compare_field("word_a", want.word_a, m_axis_tdata[27:12]);
            compare_field("word_b", want.word_b, m_axis_tdata[43:28]);
            compare_field("word_c", want.word_c, m_axis_tdata[59:44]);
            compare_field("byte_a", 16'(want.byte_a), 16'(m_axis_tdata[67:60]));
            compare_field("byte_b", 16'(want.byte_b), 16'(m_axis_tdata[75:68]));
        end
    endtask

    // Result side: random stalls, stretches without them, and one long hold-off on request.
    initial begin : result_sink
        int   stall;
        logic rcv_burst;
        rcv_burst = 1'b0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_armed) begin
                long_hold_armed = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if ($urandom_range(0, 39) == 0) rcv_burst = !rcv_burst;
            stall = rcv_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            check_result();
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        t_line_item  it;
        logic [15:0] guard_val;
        logic [15:0] timeout_val;
        int          row;
        int          phase_no;
        int          budget;
        int          start_count;
        fail_count = 0;
        items_sent = 0;
        settings_count = 0;
        results_checked = 0;
        exchanges_ok = 0;
        error_reports = 0;
        sender_burst = 1'b0;
        long_hold_armed = 1'b0;
        link_phase = PH_IDLE;
        req_cmd = '0;
        req_value = '0;
        echo_pos = '0;
        reply_pos = '0;
        reply_acc = '0;
        quiet_ms = '0;
        send_gap_ms = '0;
        guard_setting = GUARD_RESET;
        timeout_setting = TIMEOUT_RESET;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= CFG_GUARD;
        i_cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_REQUEST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (row == CONFIG_ROW) settle_and_write(16'd0, 16'd0);
            it.op = DIRECTED[row].op;
            it.cmd = DIRECTED[row].cmd;
            it.value = DIRECTED[row].value;
            it.rx = DIRECTED[row].rx;
            present_item(it, $urandom_range(0, 5), DIRECTED[row].typed, DIRECTED[row].status);
        end

        for (phase_no = 0; phase_no < 6; phase_no++) begin
            case (phase_no)
                0: begin
                    guard_val = 16'd1;
                    timeout_val = COUNT_MAX;
                end
                1: begin
                    guard_val = COUNT_MAX;
                    timeout_val = TIMEOUT_RESET;
                end
                2: begin
                    guard_val = 16'd0;
                    timeout_val = 16'd0;
                end
                3: begin
                    guard_val = 16'($urandom_range(0, 4));
                    timeout_val = 16'($urandom_range(1, 30));
                end
                4: begin
                    guard_val = 16'($urandom_range(2, 6));
                    timeout_val = 16'($urandom_range(8, 40));
                end
                default: begin
                    guard_val = 16'($urandom_range(0, 2));
                    timeout_val = 16'($urandom_range(0, 65535));
                end
            endcase
            settle_and_write(guard_val, timeout_val);
            // The sender keeps offering while the result side holds off, so the block backs up.
            if (phase_no == 3) long_hold_armed = 1'b1;
            budget = (guard_val == COUNT_MAX) ? 15 : 40;
            start_count = items_sent;
            while (items_sent - start_count < budget) begin
                sender_burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) != 0) queue_exchange();
                else queue_noise($urandom_range(1, 6));
                drive_queued();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Drove %0d input requests across %0d register settings; %0d results checked.",
                 items_sent, settings_count, results_checked);
        $display("Completed exchanges seen: %0d; error-status results seen: %0d.",
                 exchanges_ok, error_reports);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
